@@ design/pcp_pkg.sv @@
package pcp_pkg;

    // sample and run limits
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 65536;

    // accumulator widths
    localparam int CNT_W  = $clog2(MAX_SAMPLES) + 1;
    localparam int SUM_W  = 33;
    localparam int SUMQ_W = 48;

    // one finished run handed from the accumulator to the finisher
    typedef struct packed {
        logic [CNT_W-1:0]  n;
        logic [SUM_W-1:0]  sx;
        logic [SUM_W-1:0]  sy;
        logic [SUMQ_W-1:0] sxx;
        logic [SUMQ_W-1:0] syy;
        logic [SUMQ_W-1:0] sxy;
    } t_job;

    // queue status seen by the top level and the back
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] level;
    } t_qstat;

endpackage

@@ design/pearson_correlation_pair_unit.sv @@
// Pearson correlation of runs of paired signed samples. One (x, y) word is taken per
// cycle while the run queue has room; the word flagged last closes the run, whose sums
// move to a two-entry queue, and the accumulator starts the next run at once. Each run
// is finished by one shared shift-add multiplier (seven products), a two-bit-per-cycle
// square root and a bit-serial divide; a run with zero variance stops after the fourth
// product. full rises only when two closed runs are waiting. The result is signed
// Q1.15 held in an output register until popped, zero_variance marks a flat run.
module pearson_correlation_pair_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_x_sample,
    input  logic [15:0] i_y_sample,
    input  logic        i_last_sample,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_correlation,
    output logic        o_zero_variance
);
    import pcp_pkg::*;

    t_job   job_in, job_out;
    t_qstat qstat;
    logic   job_push, job_pop, accept;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    // front: accumulate words of a run
    pcp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_x_sample    (i_x_sample),
        .i_y_sample    (i_y_sample),
        .i_last_sample (i_last_sample),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    // queue of closed runs
    pcp_job_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_stat  (qstat)
    );

    // back: finish one run at a time
    pcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job_out),
        .i_qstat         (qstat),
        .o_job_pop       (job_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_correlation   (o_correlation),
        .o_zero_variance (o_zero_variance)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level != 2'd3) else $error("run queue level out of range");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_zero_variance) |-> (o_correlation == 16'd0))
        else $error("flat run with nonzero correlation");

    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_correlation != 16'h8000)) else $error("correlation not saturated");

    a_pop_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_pop && !job_push) |=> (qstat.level == $past(qstat.level) - 2'd1))
        else $error("run queue level slip");
`endif

endmodule

@@ design/pcp_front.sv @@
module pcp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [15:0]       i_x_sample,
    input  logic [15:0]       i_y_sample,
    input  logic              i_last_sample,
    output logic              o_job_push,
    output pcp_pkg::t_job     o_job
);
    import pcp_pkg::*;

    logic [CNT_W-1:0]  r_n,   n_n;
    logic [SUM_W-1:0]  r_sx,  n_sx;
    logic [SUM_W-1:0]  r_sy,  n_sy;
    logic [SUMQ_W-1:0] r_sxx, n_sxx;
    logic [SUMQ_W-1:0] r_syy, n_syy;
    logic [SUMQ_W-1:0] r_sxy, n_sxy;

    logic [15:0] xe, ye;
    logic [31:0] pxx, pyy, pxy;
    logic        room;

    // sign extend the used sample bits
    assign xe = {{(17-SAMPLE_BITS){i_x_sample[SAMPLE_BITS-1]}},
                 i_x_sample[SAMPLE_BITS-2:0]};
    assign ye = {{(17-SAMPLE_BITS){i_y_sample[SAMPLE_BITS-1]}},
                 i_y_sample[SAMPLE_BITS-2:0]};

    assign pxx = 32'($signed(xe) * $signed(xe));
    assign pyy = 32'($signed(ye) * $signed(ye));
    assign pxy = 32'($signed(xe) * $signed(ye));

    assign room = (r_n < CNT_W'(MAX_SAMPLES));

    // sums including the current word while the run has room
    always_comb begin
        n_n   = r_n;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        n_sxy = r_sxy;
        if (room) begin
            n_n   = r_n + CNT_W'(1);
            n_sx  = r_sx + {{(SUM_W-16){xe[15]}}, xe};
            n_sy  = r_sy + {{(SUM_W-16){ye[15]}}, ye};
            n_sxx = r_sxx + {{(SUMQ_W-32){1'b0}}, pxx};
            n_syy = r_syy + {{(SUMQ_W-32){1'b0}}, pyy};
            n_sxy = r_sxy + {{(SUMQ_W-32){pxy[31]}}, pxy};
        end
    end

    assign o_job_push = i_accept && i_last_sample;
    assign o_job = '{n: n_n, sx: n_sx, sy: n_sy, sxx: n_sxx, syy: n_syy, sxy: n_sxy};

    // accumulate, clear on reset and after the last word of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_job_push) begin
            r_n   <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (i_accept) begin
            r_n   <= n_n;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_sxy <= n_sxy;
        end
    end

endmodule

@@ design/pcp_job_fifo.sv @@
module pcp_job_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcp_pkg::t_job     i_data,
    input  logic              i_pop,
    output pcp_pkg::t_job     o_data,
    output pcp_pkg::t_qstat   o_stat
);
    import pcp_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_level;
    logic       do_push, do_pop;

    assign o_stat.full  = (r_level == 2'd2);
    assign o_stat.empty = (r_level == 2'd0);
    assign o_stat.level = r_level;
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_level <= r_level + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ design/pcp_back.sv @@
module pcp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcp_pkg::t_job     i_job,
    input  pcp_pkg::t_qstat   i_qstat,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [15:0]       o_correlation,
    output logic              o_zero_variance
);
    import pcp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SQRT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state         r_state;
    t_job           r_job;
    logic [2:0]     r_op;
    logic           r_ld;
    logic [127:0]   r_ma;
    logic [63:0]    r_mb;
    logic [127:0]   r_acc;
    logic [63:0]    r_tmp, r_vx, r_vy;
    logic [64:0]    r_num;
    logic [123:0]   r_d;
    logic [65:0]    r_rem;
    logic [61:0]    r_root;
    logic [5:0]     r_cnt;
    logic [15:0]    r_q;
    logic [15:0]    r_res_corr;
    logic           r_res_zv;
    logic           r_out_valid;

    logic [63:0]  opa, opb;
    logic [63:0]  ax, ay, axy, n64;
    logic         sx_neg, sy_neg, sxy_neg;
    logic [63:0]  vy_new;
    logic [64:0]  t1, t2;
    logic [65:0]  sq_rem, sq_trial;
    logic [63:0]  mag;
    logic [65:0]  dv_rem;
    logic [15:0]  q_sat;
    logic         out_free;

    // operand magnitudes
    assign sx_neg  = r_job.sx[SUM_W-1];
    assign sy_neg  = r_job.sy[SUM_W-1];
    assign sxy_neg = r_job.sxy[SUMQ_W-1];
    assign n64 = {{(64-CNT_W){1'b0}}, r_job.n};
    assign ax  = {{(64-SUM_W){1'b0}}, (sx_neg ? SUM_W'(0) - r_job.sx : r_job.sx)};
    assign ay  = {{(64-SUM_W){1'b0}}, (sy_neg ? SUM_W'(0) - r_job.sy : r_job.sy)};
    assign axy = {{(64-SUMQ_W){1'b0}}, (sxy_neg ? SUMQ_W'(0) - r_job.sxy : r_job.sxy)};

    // operand select for each multiply of the sequence
    always_comb begin
        case (r_op)
            3'd0:    begin opa = n64; opb = {{(64-SUMQ_W){1'b0}}, r_job.sxx}; end
            3'd1:    begin opa = ax;  opb = ax; end
            3'd2:    begin opa = n64; opb = {{(64-SUMQ_W){1'b0}}, r_job.syy}; end
            3'd3:    begin opa = ay;  opb = ay; end
            3'd4:    begin opa = n64; opb = axy; end
            3'd5:    begin opa = ax;  opb = ay; end
            default: begin opa = r_vx; opb = r_vy; end
        endcase
    end

    assign vy_new = r_tmp - r_acc[63:0];
    assign t1 = sxy_neg ? 65'd0 - {1'b0, r_tmp} : {1'b0, r_tmp};
    assign t2 = (sx_neg ^ sy_neg) ? 65'd0 - {1'b0, r_acc[63:0]} : {1'b0, r_acc[63:0]};

    // square root step, two radicand bits per cycle
    assign sq_rem   = {r_rem[63:0], r_d[123:122]};
    assign sq_trial = {2'b00, r_root, 2'b01};

    // divide step on the shifted remainder
    assign mag    = r_num[64] ? 64'(65'd0 - r_num) : r_num[63:0];
    assign dv_rem = {r_rem[64:0], 1'b0};
    assign q_sat  = (r_q > 16'd32767) ? 16'd32767 : r_q;

    assign out_free  = !r_out_valid || i_pop;
    assign o_job_pop = (r_state == ST_IDLE) && !i_qstat.empty;

    // finisher sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_job   <= i_job;
                        r_op    <= 3'd0;
                        r_ld    <= 1'b1;
                        r_mb    <= '0;
                        r_acc   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_ld) begin
                        // operands of the current multiply
                        r_ma  <= {64'd0, opa};
                        r_mb  <= opb;
                        r_acc <= '0;
                        r_ld  <= 1'b0;
                    end else if (r_mb != '0) begin
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma <= {r_ma[126:0], 1'b0};
                        r_mb <= {1'b0, r_mb[63:1]};
                    end else begin
                        case (r_op)
                            3'd1: r_vx <= r_tmp - r_acc[63:0];
                            3'd3: r_vy <= vy_new;
                            3'd5: r_num <= t1 - t2;
                            3'd6: r_d <= r_acc[123:0];
                            default: r_tmp <= r_acc[63:0];
                        endcase
                        r_acc <= '0;
                        if (r_op == 3'd3 && (r_vx == '0 || vy_new == '0)) begin
                            r_res_corr <= '0;
                            r_res_zv   <= 1'b1;
                            r_state    <= ST_OUT;
                        end else if (r_op == 3'd6) begin
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_SQRT;
                        end else begin
                            r_op <= r_op + 3'd1;
                            r_ld <= 1'b1;
                        end
                    end
                end
                ST_SQRT: begin
                    r_d <= {r_d[121:0], 2'b00};
                    if (sq_rem >= sq_trial) begin
                        r_rem  <= sq_rem - sq_trial;
                        r_root <= {r_root[60:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem;
                        r_root <= {r_root[60:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd61) begin
                        r_cnt   <= '0;
                        r_q     <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == 6'd0 && (r_root == '0 || mag >= {2'b00, r_root})) begin
                        // magnitude of one or more
                        r_res_corr <= r_num[64] ? 16'd0 - 16'd32767 : 16'd32767;
                        r_res_zv   <= 1'b0;
                        r_state    <= ST_OUT;
                    end else if (r_cnt == 6'd16) begin
                        r_res_corr <= r_num[64] ? 16'd0 - q_sat : q_sat;
                        r_res_zv   <= 1'b0;
                        r_state    <= ST_OUT;
                    end else begin
                        logic [65:0] rem_in;
                        rem_in = (r_cnt == 6'd0) ? {1'b0, mag, 1'b0} : dv_rem;
                        if (r_cnt == 6'd15) begin
                            if (rem_in >= {4'd0, r_root}) begin
                                r_q <= r_q + 16'd1;
                            end
                        end else if (rem_in >= {4'd0, r_root}) begin
                            r_rem <= rem_in - {4'd0, r_root};
                            r_q   <= {r_q[14:0], 1'b1};
                        end else begin
                            r_rem <= rem_in;
                            r_q   <= {r_q[14:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register toward the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid     <= 1'b1;
            o_correlation   <= r_res_corr;
            o_zero_variance <= r_res_zv;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

@@ sim/tb_pearson_correlation_pair_unit.sv @@
`timescale 1ns / 1ps

module tb_pearson_correlation_pair_unit;
    import pcp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 4000;
    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        logic [15:0] corr;
        logic        zv;
    } t_coef;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        bit          last;
        bit          typed;
        logic [15:0] corr;
        bit          zv;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_x_sample;
    logic [15:0] i_y_sample;
    logic        i_last_sample;
    logic        empty;
    logic        pop;
    logic [15:0] o_correlation;
    logic        o_zero_variance;

    pearson_correlation_pair_unit dut (.*);

    // running sums of the open run
    longint cnt, sx, sy, sxx, syy, sxy;
    t_coef  coef_q[$];
    int     mismatches = 0;
    int     words_in = 0;
    int     coefs_out = 0;
    int     flat_runs = 0;
    int     cycles = 0;
    bit     hold_pop = 0;
    bit     no_idle = 0;
    int     pop_wait = 0;
    bit     running = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // exact one-pass correlation of the open run
    task automatic add_pair(input logic [15:0] xr, input logic [15:0] yr, input bit last,
                            output bit done, output t_coef c);
        longint      x, y, vx, vy;
        logic [63:0] numw, mag, den, rem, cand;
        logic [127:0] prod;
        int          q;
        bit          neg;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        done = 0;
        c.corr = '0;
        c.zv = 0;
        if (cnt < MAX_SAMPLES) begin
            cnt++;
            sx += x;
            sy += y;
            sxx += x * x;
            syy += y * y;
            sxy += x * y;
        end
        if (!last) return;
        done = 1;
        vx = cnt * sxx - sx * sx;
        vy = cnt * syy - sy * sy;
        if (vx <= 0 || vy <= 0) begin
            c.zv = 1;
        end else begin
            numw = cnt * sxy - sx * sy;
            neg = numw[63];
            mag = neg ? -numw : numw;
            prod = {64'd0, vx} * {64'd0, vy};
            den = 0;
            for (int b = 62; b >= 0; b--) begin
                cand = den | (64'd1 << b);
                if ({64'd0, cand} * {64'd0, cand} <= prod) den = cand;
            end
            if (den == 0 || mag >= den) begin
                q = 32768;
            end else begin
                rem = mag;
                q = 0;
                for (int i = 0; i < 15; i++) begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= den) begin
                        rem -= den;
                        q |= 1;
                    end
                end
                rem = rem << 1;
                if (rem >= den) q++;
            end
            if (q > 32767) q = 32767;
            c.corr = neg ? 16'(-q) : 16'(q);
        end
        cnt = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    endtask

    // offer one word and wait until it is taken
    task automatic send_word(input logic [15:0] x, input logic [15:0] y, input bit last,
                             input bit typed, input t_coef typed_c);
        int    gap;
        bit    done;
        t_coef c;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_x_sample <= x;
        i_y_sample <= y;
        i_last_sample <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        add_pair(x, y, last, done, c);
        words_in++;
        if (done) coef_q.push_back(typed ? typed_c : c);
    endtask

    // one run of random content
    task automatic send_run(input int len);
        int          style, a;
        logic [15:0] x, y;
        t_coef       none;
        style = $urandom_range(0, 4);
        a = $urandom_range(0, 7) - 4;
        none = '{corr: '0, zv: 0};
        for (int i = 0; i < len; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            case (style)
                1: begin
                    x = 16'($signed(x) >>> 6);
                    y = 16'($signed(y) >>> 6);
                end
                2: y = 16'($signed(x) * a + ($signed(y) >>> 9));
                3: x = 16'h1234;
                default: ;
            endcase
            send_word(x, y, i == len - 1, 0, none);
        end
    endtask

    // result side: check every word popped
    always @(posedge i_clk) begin
        t_coef e;
        if (running) begin
            if (pop && !empty) begin
                coefs_out++;
                if (o_zero_variance) flat_runs++;
                if (coef_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: corr=%0d zv=%0b",
                                 $signed(o_correlation), o_zero_variance);
                end else begin
                    e = coef_q.pop_front();
                    if (o_correlation !== e.corr || o_zero_variance !== e.zv) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected corr=%0d zv=%0b, got corr=%0d zv=%0b",
                                     $signed(e.corr), e.zv, $signed(o_correlation),
                                     o_zero_variance);
                    end
                end
                pop_wait = no_idle ? 0 : $urandom_range(0, 9);
                pop <= !hold_pop && pop_wait == 0;
            end else if (hold_pop) begin
                pop <= 0;
            end else if (pop_wait > 0) begin
                pop_wait--;
                pop <= 0;
            end else begin
                pop <= 1;
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // long receiver stall, started once the random part is under way
    initial begin
        wait (words_in > 300);
        hold_pop = 1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
        hold_pop = 0;
    end

    t_row rows[$];

    initial begin
        t_coef tc;
        int    n_words;
        int    n;
        push = 0;
        pop = 0;
        i_x_sample = '0;
        i_y_sample = '0;
        i_last_sample = 0;
        i_rst_n = 0;
        cnt = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        running = 1;

        // directed words: single pair, flat runs, perfect and extreme runs, a mixed run
        rows = '{
            '{16'sd7, -16'sd3, 1, 1, 16'd0, 1},
            '{16'h7fff, 16'h8000, 1, 1, 16'd0, 1},
            '{16'd1, 16'd1, 0, 0, 16'd0, 0},
            '{16'd2, 16'd2, 0, 0, 16'd0, 0},
            '{16'd3, 16'd3, 1, 1, 16'sd32767, 0},
            '{16'd1, -16'sd1, 0, 0, 16'd0, 0},
            '{16'd2, -16'sd2, 1, 1, -16'sd32767, 0},
            '{16'd5, 16'd1, 0, 0, 16'd0, 0},
            '{16'd5, 16'd9, 1, 1, 16'd0, 1},
            '{16'd4, 16'h8000, 0, 0, 16'd0, 0},
            '{16'd9, 16'h8000, 1, 1, 16'd0, 1},
            '{16'h8000, 16'h8000, 0, 0, 16'd0, 0},
            '{16'h7fff, 16'h7fff, 1, 1, 16'sd32767, 0},
            '{16'h8000, 16'h7fff, 0, 0, 16'd0, 0},
            '{16'h7fff, 16'h8000, 1, 1, -16'sd32767, 0},
            '{16'd3, 16'd1, 0, 0, 16'd0, 0},
            '{-16'sd7, 16'd4, 0, 0, 16'd0, 0},
            '{16'd100, -16'sd2, 0, 0, 16'd0, 0},
            '{16'hffff, 16'h0001, 1, 0, 16'd0, 0}
        };
        foreach (rows[i]) begin
            tc = '{corr: rows[i].corr, zv: rows[i].zv};
            send_word(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, tc);
        end

        // random runs, mostly short, one stretch with no idling
        n_words = 0;
        while (n_words < 1230) begin
            no_idle = n_words > 600 && n_words < 760;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            send_run(n);
            n_words += n;
        end
        no_idle = 0;
        push <= 0;

        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d sample words in %0d runs, %0d flat; directed extremes, random runs",
                 words_in, coefs_out, flat_runs);
        $display("with idle gaps on both sides and one long consumer stall");
        if (mismatches == 0 && coef_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches, coef_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
